### hdl/spq_pkg.sv
// Package for the sorted priority queue.
// Holds the transaction types, the command and status codes and the cell control types.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int DATA_W = 32;

	localparam logic [1:0] CMD_ENQ    = 2'd0;
	localparam logic [1:0] CMD_DEQ    = 2'd1;
	localparam logic [1:0] CMD_TRV    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [DATA_W-1:0] item_data;
		logic signed [DATA_W-1:0] item_priority;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_data;
		logic signed [DATA_W-1:0] out_priority;
		logic [1:0]               status;
		logic                     last;
	} rsp_t;

	// contents of one cell of the chain
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] prio;
	} ent_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEQ,
		OP_ROT
	} cell_op_t;

	// broadcast to every cell each cycle
	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] prio;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/spq_cell.sv
// One cell of the sorted chain: holds one entry and moves it to or from its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire spq_pkg::ent_t      left,
	input  wire logic               left_ahead,
	input  wire spq_pkg::ent_t      right,
	input  wire spq_pkg::ent_t      head,
	output spq_pkg::ent_t           ent,
	output logic                    ahead
);
	import spq_pkg::*;

	logic                     vld_q;
	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] prio_q;
	ent_t                     cur;
	ent_t                     ent_d;

	assign cur = '{vld: vld_q, data: data_q, prio: prio_q};

	// the new item belongs at or ahead of this cell
	assign ahead = !cur.vld || (cur.prio > ctrl.prio);

	always_comb begin
		ent_d = cur;
		case (ctrl.op)
			OP_INS: begin
				if (ahead && !left_ahead) begin
					ent_d.vld  = 1'b1;
					ent_d.data = ctrl.data;
					ent_d.prio = ctrl.prio;
				end else if (ahead) begin
					ent_d = left;
				end
			end
			OP_DEQ: ent_d = right;
			OP_ROT: begin
				// last occupied cell wraps the front entry around
				if (right.vld) begin
					ent_d = right;
				end else if (cur.vld) begin
					ent_d = head;
				end
			end
			default: ent_d = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= ent_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= ent_d.data;
		prio_q <= ent_d.prio;
	end

	assign ent = cur;

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
// Enqueue and dequeue: one transaction per cycle when not stalled, result presented in the
// cycle after acceptance; unused commands produce no result. Traverse of n entries: n
// results, one per cycle when not stalled, the chain rotates by one cell per result; the
// input is stalled until the last one is sent. Reset clears every cell's valid bit and the
// occupancy count; entry payloads are not cleared. The queue is empty right after reset.
// Top level: control and output register over a chain of spq_cell. Depends on spq_pkg.
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire spq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output spq_pkg::rsp_t      rsp
);
	import spq_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);

	ent_t       ent   [CAPACITY];
	logic       ahead [CAPACITY];
	cell_ctrl_t ctrl;

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] cnt_q;
	logic             busy_q;
	logic             rsp_vld_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	logic out_free;
	logic acc;
	logic emit;
	logic full;
	logic empty;

	assign full     = ent[CAPACITY-1].vld;
	assign empty    = !ent[0].vld;
	assign out_free = !rsp_vld_q || !rsp_stall;
	assign req_stall = busy_q || !out_free;
	assign acc      = req_valid && !req_stall;
	assign emit     = busy_q && out_free;

	always_comb begin
		ctrl.op   = OP_NONE;
		ctrl.data = req.item_data;
		ctrl.prio = req.item_priority;
		if (acc) begin
			case (req.cmd)
				CMD_ENQ: if (!full) ctrl.op = OP_INS;
				CMD_DEQ: if (!empty) ctrl.op = OP_DEQ;
				CMD_TRV: if (!empty) ctrl.op = OP_ROT;
				default: ctrl.op = OP_NONE;
			endcase
		end else if (emit) begin
			ctrl.op = OP_ROT;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ent_t nb_left;
		ent_t nb_right;
		logic nb_ahead;

		if (i == 0) begin : g_first
			assign nb_left  = '0;
			assign nb_ahead = 1'b0;
		end else begin : g_mid
			assign nb_left  = ent[i-1];
			assign nb_ahead = ahead[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign nb_right = '0;
		end else begin : g_inner
			assign nb_right = ent[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left       (nb_left),
			.left_ahead (nb_ahead),
			.right      (nb_right),
			.head       (ent[0]),
			.ent        (ent[i]),
			.ahead      (ahead[i])
		);
	end

	// occupancy, traverse sequencing and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_INS) begin
				occ_q <= occ_q + 1'b1;
			end else if (ctrl.op == OP_DEQ) begin
				occ_q <= occ_q - 1'b1;
			end

			if (acc && req.cmd == CMD_TRV && !empty) begin
				cnt_q  <= occ_q - 1'b1;
				busy_q <= (occ_q != OCC_W'(1));
			end else if (emit) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != OCC_W'(1));
			end

			if (acc && req.cmd != CMD_UNUSED) begin
				rsp_vld_q <= 1'b1;
			end else if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (out_free) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		rsp_d.out_data     = '0;
		rsp_d.out_priority = '0;
		rsp_d.status       = ST_OK;
		rsp_d.last         = 1'b1;
		if (emit) begin
			rsp_d.out_data     = ent[0].data;
			rsp_d.out_priority = ent[0].prio;
			rsp_d.last         = (cnt_q == OCC_W'(1));
		end else begin
			case (req.cmd)
				CMD_ENQ: begin
					if (full) rsp_d.status = ST_FULL;
				end
				CMD_DEQ: begin
					if (empty) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						rsp_d.out_data     = ent[0].data;
						rsp_d.out_priority = ent[0].prio;
					end
				end
				CMD_TRV: begin
					if (empty) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						rsp_d.out_data     = ent[0].data;
						rsp_d.out_priority = ent[0].prio;
						rsp_d.last         = (occ_q == OCC_W'(1));
					end
				end
				default: rsp_d.status = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc || emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_head_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != '0) == ent[0].vld)
		else $error("front cell valid disagrees with occupancy");

	a_tail_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == OCC_W'(CAPACITY)) == ent[CAPACITY-1].vld)
		else $error("last cell valid disagrees with occupancy");

	a_trv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0 && cnt_q < occ_q))
		else $error("traverse count out of range");
`endif

endmodule

`default_nettype wire
